// File: hdl/prd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partitioned Rice decoder package
// Payload types, result kind codes, register indexes and parameter defaults
// shared by the decoder and its output buffer.
// ----------------------------------------------------------------------------
package prd_pkg;

  // Default values for the top-level parameters.
  localparam int DEF_ORDER_FIELD_BITS = 4;
  localparam int DEF_PARAM_FIELD_BITS = 5;
  localparam int DEF_MAX_BLOCK        = 4096;
  localparam int DEF_SAMPLE_BITS      = 32;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BLK_LEN      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORDER_OFFSET = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PARAM_OFFSET = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RICE_LOW     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RICE_HIGH    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BLANK_CODE   = 3'd5;

  // Result kind codes.
  localparam logic [1:0] KIND_SAMPLE   = 2'd0;
  localparam logic [1:0] KIND_ZERO_RUN = 2'd1;
  localparam logic [1:0] KIND_SKIP_RUN = 2'd2;

  // One coded bit.
  typedef struct packed {
    logic bit_req;
    logic restart;
  } bit_item_t;

  // One decoded result.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] sample;
    logic [12:0]        run_length;
    logic [15:0]        partition_number;
    logic               last_in_block;
  } result_t;

endpackage

// File: hdl/partitioned_rice_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partitioned Rice decoder
// Decodes a partitioned Rice coded bitstream, one bit per transaction, into
// samples, zero-run results and skipped-run results.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                 | Payload
//  bit     | in        | bit_valid / bit_stall     | bit_data (bit_req, restart)
//  result  | out       | result_valid / result_stall | result_data
//  cfg     | in        | cfg_write                 | cfg_index, cfg_data
//
// One bit is taken every cycle while bit_stall is low; a bit that completes a
// result shows it on the result port in the cycle after acceptance at the earliest.
// The decode state advances once per accepted bit: the longest path is
// the quotient shift, remainder add and unzigzag of a finished sample.
// Reset (rst, synchronous) clears the decode state and loads register defaults.
// bit_stall rises only when both the output register and its skid stage hold
// results, and falls right after the edge at which the result port accepts.
// ----------------------------------------------------------------------------
module partitioned_rice_decoder #(
  parameter int ORDER_FIELD_BITS = prd_pkg::DEF_ORDER_FIELD_BITS,
  parameter int PARAM_FIELD_BITS = prd_pkg::DEF_PARAM_FIELD_BITS,
  parameter int MAX_BLOCK        = prd_pkg::DEF_MAX_BLOCK,
  parameter int SAMPLE_BITS      = prd_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             bit_valid,
  output logic                             bit_stall,
  input  prd_pkg::bit_item_t               bit_data,
  output logic                             result_valid,
  input  logic                             result_stall,
  output prd_pkg::result_t                 result_data,
  input  logic                             cfg_write,
  input  logic [prd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import prd_pkg::*;

  typedef enum logic [1:0] {
    PH_ORDER,
    PH_PARAM,
    PH_UNARY,
    PH_REM
  } phase_t;

  localparam logic [31:0] SAMPLE_MASK = 32'hFFFF_FFFF >> (32 - SAMPLE_BITS);
  localparam logic [31:0] SAMPLE_HALF = 32'd1 << (SAMPLE_BITS - 1);

  // Configuration registers.
  logic [12:0] blk_len;
  logic [3:0]  order_offset;
  logic [3:0]  param_offset;
  logic [4:0]  rice_low;
  logic [4:0]  rice_high;
  logic [4:0]  blank_code;

  // Decode state.
  phase_t      phase, phase_next;
  logic [4:0]  field_bit_count, field_bit_count_next;
  logic [3:0]  partition_order, partition_order_next;
  logic [15:0] part_idx, part_idx_next;
  logic [4:0]  rice_k, rice_k_next;
  logic [31:0] quotient, quotient_next;
  logic [31:0] remainder_acc, remainder_acc_next;
  logic [12:0] samples_left, samples_left_next;

  // Working signals.
  logic        accept;
  phase_t      phase_cur;
  logic [4:0]  count_cur;
  logic [31:0] acc_cur;
  logic [15:0] pidx_cur;
  logic [31:0] acc_shift;
  logic [4:0]  count_inc;
  logic [8:0]  ord_sum;
  logic [5:0]  par_sum;
  logic        is_rice;
  logic [12:0] eff_block;
  logic [12:0] part_size;
  logic [16:0] part_count;
  logic        last_part;
  logic [15:0] pidx_inc;
  logic        block_done;
  logic [31:0] folded;
  logic [31:0] zz;
  logic [31:0] sample_val;
  logic        part_end;
  logic        sample_done;
  logic        emit;
  result_t     res;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_len      <= 13'd4096;
      order_offset <= 4'd0;
      param_offset <= 4'd0;
      rice_low     <= 5'd0;
      rice_high    <= 5'd30;
      blank_code   <= 5'd31;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLK_LEN:      blk_len      <= cfg_data;
        REG_ORDER_OFFSET: order_offset <= cfg_data[3:0];
        REG_PARAM_OFFSET: param_offset <= cfg_data[3:0];
        REG_RICE_LOW:     rice_low     <= cfg_data[4:0];
        REG_RICE_HIGH:    rice_high    <= cfg_data[4:0];
        REG_BLANK_CODE:   blank_code   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign accept = bit_valid && !bit_stall;

  // A restart bit drops the sub-block and is read as a fresh order field bit.
  assign phase_cur = bit_data.restart ? PH_ORDER : phase;
  assign count_cur = bit_data.restart ? 5'd0 : field_bit_count;
  assign acc_cur   = bit_data.restart ? 32'd0 : remainder_acc;
  assign pidx_cur  = bit_data.restart ? 16'd0 : part_idx;

  assign acc_shift = {acc_cur[30:0], bit_data.bit_req};
  assign count_inc = count_cur + 5'd1;

  // Field values with their offsets added.
  assign ord_sum = 9'(acc_shift[ORDER_FIELD_BITS-1:0]) + 9'(order_offset);
  assign par_sum = 6'(acc_shift[PARAM_FIELD_BITS-1:0]) + 6'(param_offset);
  assign is_rice = (par_sum >= {1'b0, rice_low}) && (par_sum <= {1'b0, rice_high});

  // Partition geometry for the current order.
  assign eff_block  = (17'(blk_len) > 17'(MAX_BLOCK)) ? 13'(MAX_BLOCK) : blk_len;
  assign part_size  = eff_block >> partition_order;
  assign part_count = 17'd1 << partition_order;
  assign last_part  = (17'(pidx_cur) + 17'd1) == part_count;
  assign pidx_inc   = pidx_cur + 16'd1;
  assign block_done = (17'(pidx_inc) >= part_count) || (pidx_inc == 16'd0);

  // Folded value and its unzigzagged, sign-extended sample.
  assign folded = (phase_cur == PH_REM) ? ((quotient << rice_k) + acc_shift) : quotient;
  assign zz = (((folded & SAMPLE_MASK) >> 1) ^ {32{folded[0]}}) & SAMPLE_MASK;
  assign sample_val = (zz ^ SAMPLE_HALF) - SAMPLE_HALF;

  // Next decode state and result for one accepted bit.
  always_comb begin
    phase_next           = phase_cur;
    field_bit_count_next = count_cur;
    partition_order_next = partition_order;
    part_idx_next        = pidx_cur;
    rice_k_next          = rice_k;
    quotient_next        = quotient;
    remainder_acc_next   = acc_cur;
    samples_left_next    = samples_left;
    part_end             = 1'b0;
    sample_done          = 1'b0;
    emit                 = 1'b0;
    res                  = '0;

    case (phase_cur)
      PH_ORDER: begin
        remainder_acc_next   = acc_shift;
        field_bit_count_next = count_inc;
        if (count_inc >= 5'(ORDER_FIELD_BITS)) begin
          partition_order_next = (ord_sum > 9'd15) ? 4'd15 : ord_sum[3:0];
          part_idx_next        = 16'd0;
          phase_next           = PH_PARAM;
          field_bit_count_next = 5'd0;
          remainder_acc_next   = 32'd0;
        end
      end
      PH_PARAM: begin
        remainder_acc_next   = acc_shift;
        field_bit_count_next = count_inc;
        if (count_inc >= 5'(PARAM_FIELD_BITS)) begin
          if (is_rice) begin
            rice_k_next       = par_sum[4:0];
            samples_left_next = part_size;
            quotient_next     = 32'd0;
            if (part_size == 13'd0) begin
              part_end = 1'b1;
            end else begin
              phase_next = PH_UNARY;
            end
          end else begin
            emit                 = 1'b1;
            res.kind             = (par_sum == {1'b0, blank_code}) ? KIND_ZERO_RUN
                                                                    : KIND_SKIP_RUN;
            res.run_length       = part_size;
            res.partition_number = pidx_cur;
            res.last_in_block    = last_part;
            part_end             = 1'b1;
          end
        end
      end
      PH_UNARY: begin
        if (bit_data.bit_req) begin
          quotient_next = quotient + 32'd1;
        end else if (rice_k == 5'd0) begin
          sample_done = 1'b1;
        end else begin
          phase_next           = PH_REM;
          field_bit_count_next = 5'd0;
          remainder_acc_next   = 32'd0;
        end
      end
      default: begin
        remainder_acc_next   = acc_shift;
        field_bit_count_next = count_inc;
        if (count_inc >= rice_k) begin
          sample_done = 1'b1;
        end
      end
    endcase

    // A finished sample is emitted and counted off its partition.
    if (sample_done) begin
      emit                 = 1'b1;
      res.kind             = KIND_SAMPLE;
      res.sample           = sample_val;
      res.partition_number = pidx_cur;
      res.last_in_block    = last_part && (samples_left == 13'd1);
      samples_left_next    = (samples_left != 13'd0) ? samples_left - 13'd1 : 13'd0;
      phase_next           = PH_UNARY;
      quotient_next        = 32'd0;
      if (samples_left_next == 13'd0) begin
        part_end = 1'b1;
      end
    end

    // Move to the next partition, or back to the order field at block end.
    if (part_end) begin
      field_bit_count_next = 5'd0;
      remainder_acc_next   = 32'd0;
      if (block_done) begin
        phase_next    = PH_ORDER;
        part_idx_next = 16'd0;
      end else begin
        phase_next    = PH_PARAM;
        part_idx_next = pidx_inc;
      end
    end
  end

  // Decode state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_ORDER;
      field_bit_count <= 5'd0;
      partition_order <= 4'd0;
      part_idx        <= 16'd0;
      rice_k          <= 5'd0;
      quotient        <= 32'd0;
      remainder_acc   <= 32'd0;
      samples_left    <= 13'd0;
    end else if (accept) begin
      phase           <= phase_next;
      field_bit_count <= field_bit_count_next;
      partition_order <= partition_order_next;
      part_idx        <= part_idx_next;
      rice_k          <= rice_k_next;
      quotient        <= quotient_next;
      remainder_acc   <= remainder_acc_next;
      samples_left    <= samples_left_next;
    end
  end

  // Result register with skid stage.
  prd_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (accept && emit),
    .push_data  (res),
    .full       (bit_stall),
    .pop_valid  (result_valid),
    .pop_stall  (result_stall),
    .pop_data   (result_data)
  );

endmodule

// File: hdl/prd_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partitioned Rice decoder output buffer
// Output register with a one-entry skid stage, so that a result can be taken
// in while the one in front is stalled.
// ----------------------------------------------------------------------------
module prd_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  prd_pkg::result_t push_data,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop_stall,
  output prd_pkg::result_t pop_data
);
  import prd_pkg::*;

  logic    main_valid;
  result_t main_data;
  logic    skid_valid;
  result_t skid_data;

  // Control state of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || !pop_stall) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push_valid;
      end
    end else if (push_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload follows the same choices; it needs no reset.
  always_ff @(posedge clk) begin
    if (!main_valid || !pop_stall) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push_valid) begin
        main_data <= push_data;
      end
    end else if (push_valid) begin
      skid_data <= push_data;
    end
  end

  assign full      = skid_valid;
  assign pop_valid = main_valid;
  assign pop_data  = main_data;

endmodule
